>>> rtl/rsd_pkg.sv
// Shared types for the radial stick deadzone pipeline.
`timescale 1ns / 1ps
package rsd_pkg;

	// per-stage control handed to each cell of the chains
	typedef struct packed {
		logic adv;   // pipeline moves this cycle
		logic vld;   // the cell's input holds a live request
	} cell_ctl_t;

endpackage

>>> rtl/rsd_sqrt_cell.sv
// One digit cell of the integer square root chain (two radicand bits per cell).
`timescale 1ns / 1ps
module rsd_sqrt_cell #(
	parameter int W = 16
) (
	input  logic                 clk,
	input  rsd_pkg::cell_ctl_t   ctl,
	input  logic [W:0]           rem_i,
	input  logic [W-1:0]         root_i,
	input  logic [2*W-1:0]       sq_i,
	output logic [W:0]           rem_q,
	output logic [W-1:0]         root_q,
	output logic [2*W-1:0]       sq_q
);
	logic [W+2:0] t;
	logic [W+2:0] trial;
	logic         ge;

	always_comb begin
		t     = {rem_i, sq_i[2*W-1:2*W-2]};
		trial = {1'b0, root_i, 2'b01};
		ge    = (t >= trial);
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.vld) begin
			rem_q  <= ge ? (W+1)'(t - trial) : t[W:0];
			root_q <= {root_i[W-2:0], ge};
			sq_q   <= {sq_i[2*W-3:0], 2'b00};
		end
	end
endmodule

>>> rtl/rsd_div_cell.sv
// One quotient bit of a restoring divider chain.
`timescale 1ns / 1ps
module rsd_div_cell #(
	parameter int DW = 16,
	parameter int QW = 16,
	parameter int NW = 16
) (
	input  logic                 clk,
	input  rsd_pkg::cell_ctl_t   ctl,
	input  logic [DW-1:0]        rem_i,
	input  logic [DW-1:0]        d_i,
	input  logic [QW-1:0]        q_i,
	input  logic [NW-1:0]        n_i,
	output logic [DW-1:0]        rem_q,
	output logic [DW-1:0]        d_q,
	output logic [QW-1:0]        q_q,
	output logic [NW-1:0]        n_q
);
	logic [DW:0] t;
	logic        ge;

	always_comb begin
		t  = {rem_i, n_i[NW-1]};
		ge = (t >= {1'b0, d_i});
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.vld) begin
			rem_q <= ge ? DW'(t - {1'b0, d_i}) : t[DW-1:0];
			d_q   <= d_i;
			q_q   <= {q_i[QW-2:0], ge};
			n_q   <= n_i << 1;
		end
	end
endmodule

>>> rtl/radial_stick_deadzone.sv
// Scaled radial deadzone for a two-axis stick sample, pipelined as chains of cells.
//
// channel   | dir | tdata (low bit up)   | tuser
// s_*       | in  | x_in, y_in           | -
// m_*       | out | x_out, y_out         | inside_deadzone
// cfg_*     | in  | deadzone_radius      | -
//
// One request per cycle unless m_tready stalls; the stages are the root chain
// (SAMPLE_BITS cells), the two divider chains (SAMPLE_BITS-1 and SAMPLE_BITS cells) and the registers around them.
// Reset clears the valid chain and loads the radius with about 0.20.
// A stall on m_tready freezes the whole pipeline; s_tready follows it.
`timescale 1ns / 1ps
module radial_stick_deadzone #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // x_in, y_in
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,  // x_out, y_out
	output logic                                   m_tuser,  // inside_deadzone
	input  logic                                   cfg_we,
	input  logic [SAMPLE_BITS-2:0]                 cfg_wdata
);
	localparam int W        = SAMPLE_BITS;
	localparam int F        = W - 1;
	localparam int TW       = ((2*W+7)/8)*8;
	localparam int NST      = 3*W + 4;
	localparam int DZ_RESET = (2**(F+1) + 5) / 10;
	localparam logic [W-1:0] ONE = W'(1) << F;
	localparam int SW1 = 2*W + 2;        // xn, yn, ax, ay
	localparam int SW2 = 3*W + 4;        // + mag, inside, sat

	logic [F-1:0]   radius_q;
	logic [NST-1:0] vld_q;
	logic           adv;

	assign adv      = !vld_q[NST-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= F'(DZ_RESET);
			vld_q    <= '0;
		end else begin
			if (cfg_we) radius_q <= cfg_wdata;
			if (adv) vld_q <= {vld_q[NST-2:0], s_tvalid};
		end
	end

	// abs, squares and their sum
	logic [W-1:0]   xi, yi, ax_c, ay_c, ax_s1, ay_s1;
	logic           xn_s1, yn_s1;
	logic [2*W-1:0] xx_s1, yy_s1, sq_s2;
	logic [SW1-1:0] sd_s2;

	always_comb begin
		xi   = s_tdata[W-1:0];
		yi   = s_tdata[2*W-1:W];
		ax_c = xi[W-1] ? (~xi + 1'b1) : xi;
		ay_c = yi[W-1] ? (~yi + 1'b1) : yi;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= ax_c;
			ay_s1 <= ay_c;
			xn_s1 <= xi[W-1];
			yn_s1 <= yi[W-1];
			xx_s1 <= (2*W)'(ax_c) * (2*W)'(ax_c);
			yy_s1 <= (2*W)'(ay_c) * (2*W)'(ay_c);
			sq_s2 <= xx_s1 + yy_s1;
			sd_s2 <= {xn_s1, yn_s1, ax_s1, ay_s1};
		end
	end

	// square root chain
	logic [W:0]     rt_rem [0:W];
	logic [W-1:0]   rt_root [0:W];
	logic [2*W-1:0] rt_sq [0:W];
	logic [SW1-1:0] rt_sd [0:W];

	assign rt_rem[0]  = '0;
	assign rt_root[0] = '0;
	assign rt_sq[0]   = sq_s2;
	assign rt_sd[0]   = sd_s2;

	for (genvar i = 0; i < W; i++) begin : g_sqrt
		rsd_pkg::cell_ctl_t ctl;
		assign ctl = '{adv: adv, vld: vld_q[1+i]};
		rsd_sqrt_cell #(.W(W)) u_cell (
			.clk(clk), .ctl(ctl),
			.rem_i(rt_rem[i]), .root_i(rt_root[i]), .sq_i(rt_sq[i]),
			.rem_q(rt_rem[i+1]), .root_q(rt_root[i+1]), .sq_q(rt_sq[i+1])
		);
		always_ff @(posedge clk) begin
			if (adv) rt_sd[i+1] <= rt_sd[i];
		end
	end

	// radius compare and first divider setup
	logic [W-1:0]   mag;
	logic [W-1:0]   n_d0, d_d0;
	logic [SW2-1:0] sd_d0;

	assign mag = rt_root[W];

	always_ff @(posedge clk) begin
		if (adv) begin
			n_d0  <= mag - {1'b0, radius_q};
			d_d0  <= ONE - {1'b0, radius_q};
			sd_d0 <= {rt_sd[W], mag, (mag <= {1'b0, radius_q}), mag[W-1]};
		end
	end

	// remap divider: (mag - r) * 2^F / (1 - r)
	logic [W-1:0]   d1_rem [0:F];
	logic [W-1:0]   d1_d [0:F];
	logic [F-1:0]   d1_q [0:F];
	logic [0:0]     d1_n [0:F];
	logic [SW2-1:0] d1_sd [0:F];

	assign d1_rem[0] = n_d0;
	assign d1_d[0]   = d_d0;
	assign d1_q[0]   = '0;
	assign d1_n[0]   = 1'b0;
	assign d1_sd[0]  = sd_d0;

	for (genvar j = 0; j < F; j++) begin : g_div1
		rsd_pkg::cell_ctl_t ctl;
		assign ctl = '{adv: adv, vld: vld_q[W+2+j]};
		rsd_div_cell #(.DW(W), .QW(F), .NW(1)) u_cell (
			.clk(clk), .ctl(ctl),
			.rem_i(d1_rem[j]), .d_i(d1_d[j]), .q_i(d1_q[j]), .n_i(d1_n[j]),
			.rem_q(d1_rem[j+1]), .d_q(d1_d[j+1]), .q_q(d1_q[j+1]), .n_q(d1_n[j+1])
		);
		always_ff @(posedge clk) begin
			if (adv) d1_sd[j+1] <= d1_sd[j];
		end
	end

	// scale both axes by the remapped length
	logic           xn_e, yn_e, in_e, sat_e;
	logic [W-1:0]   ax_e, ay_e, mag_e, legal;
	logic [2*W-1:0] px_m, py_m;
	logic [W-1:0]   mag_m;
	logic [2:0]     sd_m;

	assign {xn_e, yn_e, ax_e, ay_e, mag_e, in_e, sat_e} = d1_sd[F];
	assign legal = sat_e ? ONE : {1'b0, d1_q[F]};

	always_ff @(posedge clk) begin
		if (adv) begin
			px_m  <= (2*W)'(ax_e) * (2*W)'(legal);
			py_m  <= (2*W)'(ay_e) * (2*W)'(legal);
			mag_m <= mag_e;
			sd_m  <= {xn_e, yn_e, in_e};
		end
	end

	// direction dividers, one lane per axis
	logic [W-1:0] xr [0:W], xd [0:W], xq [0:W], xnb [0:W];
	logic [W-1:0] yr [0:W], yd [0:W], yq [0:W], ynb [0:W];
	logic [2:0]   d2_sd [0:W];

	assign xr[0]    = px_m[2*W-1:W];
	assign xnb[0]   = px_m[W-1:0];
	assign xd[0]    = mag_m;
	assign xq[0]    = '0;
	assign yr[0]    = py_m[2*W-1:W];
	assign ynb[0]   = py_m[W-1:0];
	assign yd[0]    = mag_m;
	assign yq[0]    = '0;
	assign d2_sd[0] = sd_m;

	for (genvar k = 0; k < W; k++) begin : g_div2
		rsd_pkg::cell_ctl_t ctl;
		assign ctl = '{adv: adv, vld: vld_q[2*W+2+k]};
		rsd_div_cell #(.DW(W), .QW(W), .NW(W)) u_x (
			.clk(clk), .ctl(ctl),
			.rem_i(xr[k]), .d_i(xd[k]), .q_i(xq[k]), .n_i(xnb[k]),
			.rem_q(xr[k+1]), .d_q(xd[k+1]), .q_q(xq[k+1]), .n_q(xnb[k+1])
		);
		rsd_div_cell #(.DW(W), .QW(W), .NW(W)) u_y (
			.clk(clk), .ctl(ctl),
			.rem_i(yr[k]), .d_i(yd[k]), .q_i(yq[k]), .n_i(ynb[k]),
			.rem_q(yr[k+1]), .d_q(yd[k+1]), .q_q(yq[k+1]), .n_q(ynb[k+1])
		);
		always_ff @(posedge clk) begin
			if (adv) d2_sd[k+1] <= d2_sd[k];
		end
	end

	// sign, saturate, output register
	logic [W-1:0] qx, qy, ox, oy, x_q, y_q;
	logic         xn_f, yn_f, in_f, in_q;

	assign {xn_f, yn_f, in_f} = d2_sd[W];
	assign qx = xq[W];
	assign qy = yq[W];

	always_comb begin
		ox = xn_f ? (~qx + 1'b1) : (qx[W-1] ? (ONE - 1'b1) : qx);
		oy = yn_f ? (~qy + 1'b1) : (qy[W-1] ? (ONE - 1'b1) : qy);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_q  <= in_f ? '0 : ox;
			y_q  <= in_f ? '0 : oy;
			in_q <= in_f;
		end
	end

	assign m_tdata = TW'({y_q, x_q});
	assign m_tuser = in_q;

	// checks
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("deadzone result not zero");

	a_div1_nz: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[W+2] |-> d_d0 != '0)
		else $error("remap divisor is zero");

	a_div2_nz: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[2*W+2] && !sd_m[0] |-> mag_m != '0)
		else $error("length is zero outside the deadzone");
endmodule
